// ----- rtl/albe_pkg.sv -----
// shared constants, types and codes for the antialiased line blend engine
package albe_pkg;

   // frame geometry
   localparam int FRAME_WIDTH  = 256;
   localparam int FRAME_HEIGHT = 256;
   localparam int ADDR_W       = $clog2(FRAME_WIDTH * FRAME_HEIGHT);

   // column arithmetic is carried in this signed width
   localparam int COL_W = 14;
   localparam logic signed [COL_W-1:0] FRAME_WIDTH_S = COL_W'(FRAME_WIDTH);

   // slope divider widths
   localparam int NUM_W  = 50;
   localparam int QUOT_W = 32;
   localparam int DEN_W  = 16;

   // blend constants
   localparam logic [23:0] BLEND_DEN = 24'd16711680;
   localparam logic [15:0] HALF_PIX  = 16'h8000;
   localparam logic [16:0] FULL_PIX  = 17'h10000;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [23:0]       pixel_type;

   // operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_DRAW  = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_RED   = 3'd0;
   localparam logic [2:0] CSR_GREEN = 3'd1;
   localparam logic [2:0] CSR_BLUE  = 3'd2;
   localparam logic [2:0] CSR_ALPHA = 3'd3;
   localparam logic [2:0] CSR_GAMMA = 3'd4;

   // line color and blend mode as seen by the blend unit
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       gamma;
   } blend_cfg_type;

endpackage

// ----- rtl/albe_frame_ram.sv -----
// frame store: one write port, one registered read port
module albe_frame_ram (
   input  logic                clock,
   input  logic                wr_en,
   input  albe_pkg::addr_type  wr_addr,
   input  albe_pkg::pixel_type wr_data,
   input  logic                rd_en,
   input  albe_pkg::addr_type  rd_addr,
   output albe_pkg::pixel_type rd_data
);

   albe_pkg::pixel_type mem [2**albe_pkg::ADDR_W];
   albe_pkg::pixel_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/albe_divider.sv -----
// iterative floor divider: signed numerator by positive divisor, one bit a cycle
module albe_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [albe_pkg::NUM_W-1:0]  numer,
   input  logic        [albe_pkg::DEN_W-1:0]  denom,
   output logic                               done,
   output logic signed [albe_pkg::QUOT_W-1:0] quot,
   output logic        [albe_pkg::DEN_W-1:0]  remd
);

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_RUN  = 3'b010,
      DV_FIX  = 3'b100
   } dv_state_type;

   localparam int CNT_W = $clog2(albe_pkg::NUM_W);

   dv_state_type state_ff, state_in;
   logic [albe_pkg::NUM_W-1:0] mag_ff, mag_in;
   logic [albe_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [albe_pkg::DEN_W-1:0] den_ff, den_in;
   logic                       neg_ff, neg_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       done_ff, done_in;
   logic signed [albe_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic [albe_pkg::DEN_W-1:0] remd_ff, remd_in;

   logic [albe_pkg::DEN_W:0]   trial;
   logic                       fits;
   logic [albe_pkg::NUM_W-1:0] qneg;

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      quot_in  = quot_ff;
      remd_in  = remd_ff;
      // shift-subtract step
      trial = {rem_ff, mag_ff[albe_pkg::NUM_W-1]};
      fits  = trial >= {1'b0, den_ff};
      qneg  = '0;
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               neg_in   = numer[albe_pkg::NUM_W-1];
               mag_in   = numer[albe_pkg::NUM_W-1] ? 
                          albe_pkg::NUM_W'(-numer) : albe_pkg::NUM_W'(numer);
               den_in   = denom;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in = fits ? albe_pkg::DEN_W'(trial - {1'b0, den_ff})
                          : albe_pkg::DEN_W'(trial);
            mag_in = {mag_ff[albe_pkg::NUM_W-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(albe_pkg::NUM_W - 1)) begin
               state_in = DV_FIX;
            end
         end
         DV_FIX: begin
            // round toward minus infinity for negative numerators
            if (neg_ff && rem_ff != '0) begin
               qneg    = ~mag_ff;
               remd_in = den_ff - rem_ff;
            end else if (neg_ff) begin
               qneg    = -mag_ff;
               remd_in = '0;
            end else begin
               qneg    = mag_ff;
               remd_in = rem_ff;
            end
            quot_in  = albe_pkg::QUOT_W'(qneg);
            done_in  = 1'b1;
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
      remd_ff <= remd_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign remd = remd_ff;

endmodule

// ----- rtl/albe_isqrt.sv -----
// integer square root of a 32-bit value, one root bit a cycle
module albe_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] operand,
   output logic        done,
   output logic [15:0] root
);

   logic [31:0] opnd_ff, opnd_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] root_ff, root_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;

   logic [18:0] rem_sh;
   logic [18:0] trial;

   always_comb begin
      opnd_in = opnd_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      // bring down two bits and try 4*root+1
      rem_sh  = {rem_ff, opnd_ff[31:30]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start && !run_ff) begin
         opnd_in = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         opnd_in = {opnd_ff[29:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = 17'(rem_sh - trial);
            root_in = {root_ff[14:0], 1'b1};
         end else begin
            rem_in  = 17'(rem_sh);
            root_in = {root_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 4'd15) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      opnd_ff <= opnd_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- rtl/albe_pixel_blend.sv -----
// blends the line color into one pixel, linear or square-root mode
module albe_pixel_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  albe_pkg::blend_cfg_type cfg,
   input  logic                    start,
   input  logic [16:0]             weight,
   input  albe_pkg::pixel_type     old_pixel,
   output logic                    done,
   output albe_pkg::pixel_type     new_pixel
);

   typedef enum logic [5:0] {
      BL_IDLE  = 6'b000001,
      BL_ALPHA = 6'b000010,
      BL_PROD  = 6'b000100,
      BL_SUM   = 6'b001000,
      BL_ROOT  = 6'b010000,
      BL_FIN   = 6'b100000
   } bl_state_type;

   bl_state_type state_ff, state_in;
   logic [16:0]         w_ff, w_in;
   albe_pkg::pixel_type old_ff, old_in;
   logic [23:0]         a_ff, a_in;
   logic [31:0]         pa_ff [3];
   logic [31:0]         pa_in [3];
   logic [31:0]         pb_ff [3];
   logic [31:0]         pb_in [3];
   logic [7:0]          res_ff [3];
   logic [7:0]          res_in [3];

   logic [7:0]  col_k [3];
   logic [31:0] sum   [3];
   logic [16:0] lin   [3];
   logic [15:0] root  [3];
   logic [2:0]  root_done;
   logic        root_start;

   assign col_k[0] = cfg.red;
   assign col_k[1] = cfg.green;
   assign col_k[2] = cfg.blue;
   assign root_start = (state_ff == BL_SUM) && cfg.gamma;

   // one root unit per channel
   for (genvar g = 0; g < 3; g++) begin : g_lane
      assign sum[g] = pa_ff[g] + pb_ff[g];
      // floor(sum / (255*65536)) via the high half and a divide by 255
      assign lin[g] = 17'(sum[g][31:16]) + 17'd1 + 17'(sum[g][31:24]);
      albe_isqrt u_isqrt (
         .clock   (clock),
         .reset   (reset),
         .start   (root_start),
         .operand (sum[g]),
         .done    (root_done[g]),
         .root    (root[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      w_in     = w_ff;
      old_in   = old_ff;
      a_in     = a_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      res_in   = res_ff;
      case (state_ff)
         BL_IDLE: begin
            if (start) begin
               w_in     = weight;
               old_in   = old_pixel;
               state_in = BL_ALPHA;
            end
         end
         BL_ALPHA: begin
            a_in     = 24'(w_ff * cfg.alpha);
            state_in = BL_PROD;
         end
         BL_PROD: begin
            for (int i = 0; i < 3; i++) begin
               pa_in[i] = 32'(a_ff * col_k[i]);
               pb_in[i] = 32'((albe_pkg::BLEND_DEN - a_ff) * old_ff[8*i +: 8]);
            end
            state_in = BL_SUM;
         end
         BL_SUM: begin
            for (int i = 0; i < 3; i++) begin
               res_in[i] = lin[i][15:8];
            end
            state_in = cfg.gamma ? BL_ROOT : BL_FIN;
         end
         BL_ROOT: begin
            if (root_done[0]) begin
               for (int i = 0; i < 3; i++) begin
                  res_in[i] = root[i][15:8];
               end
               state_in = BL_FIN;
            end
         end
         BL_FIN: begin
            state_in = BL_IDLE;
         end
         default: begin
            state_in = BL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BL_IDLE;
      end else begin
         state_ff <= state_in;
      end
      w_ff   <= w_in;
      old_ff <= old_in;
      a_ff   <= a_in;
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      res_ff <= res_in;
   end

   assign done      = (state_ff == BL_FIN);
   assign new_pixel = {res_ff[2], res_ff[1], res_ff[0]};

endmodule

// ----- rtl/antialiased_line_blend_engine.sv -----
// top level: command decode, segment walker and frame store read-modify-write
// a write or an unknown operation answers in the cycle after start; a read answers from
// ST_RDWAIT with the registered frame store data; a draw runs set-up, a multiply and
// two slope divisions, then per column a column step and up to two pixel updates, each
// a frame store read, a blend (gamma or linear) and a write back; one item at a time
// synchronous reset restores the line registers; frame store contents stay undefined
module antialiased_line_blend_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic signed [15:0] req_end_x,
   input  logic signed [15:0] req_end_y,
   input  logic [7:0]         req_pixel_col,
   input  logic [7:0]         req_pixel_row,
   input  logic [23:0]        req_pixel_rgb,
   output logic               rsp_valid,
   output logic [23:0]        rsp_read_rgb,
   output logic [8:0]         rsp_columns_drawn,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_data
);

   localparam int CW = albe_pkg::COL_W;
   localparam int QW = albe_pkg::QUOT_W;
   localparam int DW = albe_pkg::DEN_W;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_RDWAIT = 11'b00000000010,
      ST_SETUP  = 11'b00000000100,
      ST_MUL    = 11'b00000001000,
      ST_DIVS   = 11'b00000010000,
      ST_DIVA   = 11'b00000100000,
      ST_DIVB   = 11'b00001000000,
      ST_COL    = 11'b00010000000,
      ST_PIX    = 11'b00100000000,
      ST_PWAIT  = 11'b01000000000,
      ST_PBLEND = 11'b10000000000
   } state_type;

   // control and payload registers
   state_type state_ff, state_in;
   logic              rd_ok_ff, rd_ok_in;
   logic signed [15:0] x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic signed [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, col_ff, col_in;
   logic [DW-1:0]     dx_ff, dx_in;
   logic signed [16:0] dy_ff, dy_in;
   logic [8:0]        count_ff, count_in;
   logic signed [36:0] prod_ff, prod_in;
   logic signed [QW-1:0] q_ff, q_in, sq_ff, sq_in;
   logic [DW-1:0]     r_ff, r_in, sr_ff, sr_in;
   logic signed [15:0] row1_ff, row1_in, row2_ff, row2_in;
   logic [16:0]       w1_ff, w1_in, w2_ff, w2_in;
   logic              sel_ff, sel_in;
   albe_pkg::addr_type addr_ff, addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_rgb_ff, rsp_rgb_in;
   logic [8:0]        rsp_cols_ff, rsp_cols_in;
   albe_pkg::blend_cfg_type cfg_ff, cfg_in;

   // datapath helpers
   logic              accept;
   logic              port_inside;
   albe_pkg::addr_type port_addr;
   logic signed [16:0] dx, dy;
   logic [16:0]       adx, ady;
   logic signed [CW-1:0] lo_raw, hi_raw, lo_c, hi_c;
   logic signed [19:0] t;
   logic signed [31:0] y;
   logic [15:0]       f;
   logic [16:0]       o;
   logic signed [15:0] cur_row;
   logic [16:0]       cur_w;
   logic              row_inside;
   albe_pkg::addr_type pix_addr;
   logic [16:0]       r_sum;
   logic signed [CW-1:0] col_next;

   // submodule connections
   logic                     ram_wr_en, ram_rd_en;
   albe_pkg::addr_type       ram_wr_addr, ram_rd_addr;
   albe_pkg::pixel_type      ram_wr_data, ram_rd_data;
   logic                     div_start, div_done;
   logic signed [albe_pkg::NUM_W-1:0] div_numer;
   logic signed [QW-1:0]     div_quot;
   logic [DW-1:0]            div_rem;
   logic                     bl_start, bl_done;
   albe_pkg::pixel_type      bl_pixel;

   assign accept      = start && !busy;
   assign port_inside = (32'(req_pixel_col) < albe_pkg::FRAME_WIDTH) &&
                        (32'(req_pixel_row) < albe_pkg::FRAME_HEIGHT);
   assign port_addr   = albe_pkg::addr_type'(32'(req_pixel_row) * albe_pkg::FRAME_WIDTH
                                             + 32'(req_pixel_col));

   // segment set-up terms
   assign dx     = 17'(x2_ff) - 17'(x1_ff);
   assign dy     = 17'(y2_ff) - 17'(y1_ff);
   assign adx    = dx[16] ? 17'(-dx) : 17'(dx);
   assign ady    = dy[16] ? 17'(-dy) : 17'(dy);
   assign lo_raw = CW'(x1_ff >>> 4);
   assign hi_raw = CW'(x2_ff >>> 4);
   assign lo_c   = lo_raw[CW-1] ? '0 : lo_raw;
   assign hi_c   = (hi_raw > albe_pkg::FRAME_WIDTH_S) ? albe_pkg::FRAME_WIDTH_S : hi_raw;
   assign t      = 20'(lo_ff <<< 4) + 20'sd8 - 20'(x1_ff);

   // row position of the current column in Q.16
   assign y = {{4{y1_ff[15]}}, y1_ff, 12'b0} + q_ff;
   assign f = y[15:0];
   assign o = (f > albe_pkg::HALF_PIX) ? 17'(f - albe_pkg::HALF_PIX)
                                       : 17'(albe_pkg::HALF_PIX - f);

   // pixel under update
   assign cur_row    = sel_ff ? row2_ff : row1_ff;
   assign cur_w      = sel_ff ? w2_ff : w1_ff;
   assign row_inside = !cur_row[15] && (32'(cur_row[14:0]) < albe_pkg::FRAME_HEIGHT);
   assign pix_addr   = albe_pkg::addr_type'(32'(cur_row[14:0]) * albe_pkg::FRAME_WIDTH
                                            + 32'(col_ff[CW-2:0]));
   assign r_sum      = {1'b0, r_ff} + {1'b0, sr_ff};
   assign col_next   = col_ff + CW'(1);

   // slope divider operands, sign extended
   assign div_start = (state_ff == ST_DIVS) || ((state_ff == ST_DIVA) && div_done);
   assign div_numer = (state_ff == ST_DIVS)
                    ? albe_pkg::NUM_W'($signed({prod_ff, 12'b0}))
                    : albe_pkg::NUM_W'($signed({dy_ff, 16'b0}));

   assign bl_start = (state_ff == ST_PWAIT);

   always_comb begin
      state_in     = state_ff;
      rd_ok_in     = rd_ok_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      col_in       = col_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      q_in         = q_ff;
      sq_in        = sq_ff;
      r_in         = r_ff;
      sr_in        = sr_ff;
      row1_in      = row1_ff;
      row2_in      = row2_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      sel_in       = sel_ff;
      addr_in      = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_rgb_in   = '0;
      rsp_cols_in  = '0;
      cfg_in       = cfg_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = bl_pixel;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = pix_addr;

      // configuration writes
      if (csr_write) begin
         case (csr_index)
            albe_pkg::CSR_RED:   cfg_in.red   = csr_data;
            albe_pkg::CSR_GREEN: cfg_in.green = csr_data;
            albe_pkg::CSR_BLUE:  cfg_in.blue  = csr_data;
            albe_pkg::CSR_ALPHA: cfg_in.alpha = csr_data;
            albe_pkg::CSR_GAMMA: cfg_in.gamma = csr_data[0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x1_in = req_start_x;
               y1_in = req_start_y;
               x2_in = req_end_x;
               y2_in = req_end_y;
               case (req_operation)
                  albe_pkg::OP_WRITE: begin
                     ram_wr_en    = port_inside;
                     ram_wr_addr  = port_addr;
                     ram_wr_data  = req_pixel_rgb;
                     rsp_valid_in = 1'b1;
                  end
                  albe_pkg::OP_READ: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = port_addr;
                     rd_ok_in    = port_inside;
                     state_in    = ST_RDWAIT;
                  end
                  albe_pkg::OP_DRAW: begin
                     state_in = ST_SETUP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_rgb_in   = rd_ok_ff ? ram_rd_data : '0;
            state_in     = ST_IDLE;
         end
         // x-major rightward segments with at least one column in frame
         ST_SETUP: begin
            if (!dx[16] && dx != '0 && adx > ady && hi_c > lo_c) begin
               lo_in    = lo_c;
               hi_in    = hi_c;
               col_in   = lo_c;
               dx_in    = DW'(dx);
               dy_in    = dy;
               count_in = 9'(hi_c - lo_c);
               state_in = ST_MUL;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_MUL: begin
            prod_in  = 37'(t * dy_ff);
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            state_in = ST_DIVA;
         end
         ST_DIVA: begin
            if (div_done) begin
               q_in     = div_quot;
               r_in     = div_rem;
               state_in = ST_DIVB;
            end
         end
         ST_DIVB: begin
            if (div_done) begin
               sq_in    = div_quot;
               sr_in    = div_rem;
               state_in = ST_COL;
            end
         end
         // split coverage between the two nearest rows
         ST_COL: begin
            row1_in  = y[31:16];
            row2_in  = (f > albe_pkg::HALF_PIX) ? y[31:16] + 16'sd1 : y[31:16] - 16'sd1;
            w1_in    = albe_pkg::FULL_PIX - o;
            w2_in    = o;
            sel_in   = 1'b0;
            state_in = ST_PIX;
         end
         ST_PIX: begin
            if (row_inside) begin
               ram_rd_en = 1'b1;
               addr_in   = pix_addr;
               w1_in     = w1_ff;
               state_in  = ST_PWAIT;
            end else if (!sel_ff) begin
               sel_in = 1'b1;
            end else begin
               col_in = col_next;
               q_in   = (r_sum >= {1'b0, dx_ff}) ? q_ff + sq_ff + QW'(1) : q_ff + sq_ff;
               r_in   = (r_sum >= {1'b0, dx_ff}) ? DW'(r_sum - {1'b0, dx_ff}) : DW'(r_sum);
               if (col_next == hi_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_cols_in  = count_ff;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_COL;
               end
            end
         end
         ST_PWAIT: begin
            state_in = ST_PBLEND;
         end
         // write back the blended beat, then the second row or the next column
         ST_PBLEND: begin
            if (bl_done) begin
               ram_wr_en = 1'b1;
               if (!sel_ff) begin
                  sel_in   = 1'b1;
                  state_in = ST_PIX;
               end else begin
                  col_in = col_next;
                  q_in   = (r_sum >= {1'b0, dx_ff}) ? q_ff + sq_ff + QW'(1) : q_ff + sq_ff;
                  r_in   = (r_sum >= {1'b0, dx_ff}) ? DW'(r_sum - {1'b0, dx_ff})
                                                    : DW'(r_sum);
                  if (col_next == hi_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_cols_in  = count_ff;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_COL;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{red: 8'd0, green: 8'd255, blue: 8'd255, alpha: 8'd128,
                           gamma: 1'b1};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      rd_ok_ff    <= rd_ok_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      x2_ff       <= x2_in;
      y2_ff       <= y2_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      col_ff      <= col_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      count_ff    <= count_in;
      prod_ff     <= prod_in;
      q_ff        <= q_in;
      sq_ff       <= sq_in;
      r_ff        <= r_in;
      sr_ff       <= sr_in;
      row1_ff     <= row1_in;
      row2_ff     <= row2_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      sel_ff      <= sel_in;
      addr_ff     <= addr_in;
      rsp_rgb_ff  <= rsp_rgb_in;
      rsp_cols_ff <= rsp_cols_in;
   end

   albe_frame_ram u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   albe_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (dx_ff),
      .done  (div_done),
      .quot  (div_quot),
      .remd  (div_rem)
   );

   albe_pixel_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .start     (bl_start),
      .weight    (cur_w),
      .old_pixel (ram_rd_data),
      .done      (bl_done),
      .new_pixel (bl_pixel)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_rgb      = rsp_rgb_ff;
   assign rsp_columns_drawn = rsp_cols_ff;

endmodule

// ----- sim/tb.sv -----
// testbench for the antialiased line blend engine: directed and random commands against a predictor
`timescale 1ns / 100ps

module tb;

   localparam longint unsigned BLEND_D = 64'd16711680;
   localparam int WATCHDOG_LIMIT = 200000;
   // every pixel a random draw touches lies in this square at the top-left corner
   localparam int WIN = 16;
   // operation code with no meaning
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_operation;
   logic signed [15:0] req_start_x;
   logic signed [15:0] req_start_y;
   logic signed [15:0] req_end_x;
   logic signed [15:0] req_end_y;
   logic [7:0]         req_pixel_col;
   logic [7:0]         req_pixel_row;
   logic [23:0]        req_pixel_rgb;
   logic               rsp_valid;
   logic [23:0]        rsp_read_rgb;
   logic [8:0]         rsp_columns_drawn;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [7:0]         csr_data;

   antialiased_line_blend_engine dut (.*);

   // shadow of the block: frame contents and line registers
   logic [23:0] shadow_frame [0:65535];
   logic [7:0]  line_red, line_green, line_blue, line_opacity;
   logic        sqrt_blend;

   // expected beats, oldest first
   logic [23:0] pending_rgb [$];
   logic [8:0]  pending_cols [$];

   int mismatches;
   int idle_pct;
   int beats_sent;
   int draws_sent;
   int watchdog;

   // clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, bit_v;
      r = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= r + bit_v) begin
            n -= r + bit_v;
            r = (r >> 1) + bit_v;
         end else begin
            r >>= 1;
         end
         bit_v >>= 2;
      end
      return r;
   endfunction

   function automatic logic [7:0] mix_channel(logic [7:0] old_v, logic [7:0] k,
                                              longint unsigned a);
      longint unsigned n;
      n = a * k + (BLEND_D - a) * old_v;
      if (sqrt_blend) return 8'(int_sqrt(n) >> 8);
      return 8'(n / BLEND_D);
   endfunction

   task automatic mix_pixel(input longint col, input longint row, input longint unsigned w);
      longint unsigned a;
      logic [23:0] p;
      int idx;
      a = w * line_opacity;
      if (col < 0 || col >= albe_pkg::FRAME_WIDTH || row < 0 ||
          row >= albe_pkg::FRAME_HEIGHT) return;
      idx = int'(col) + albe_pkg::FRAME_WIDTH * int'(row);
      p = shadow_frame[idx];
      shadow_frame[idx] = {mix_channel(p[23:16], line_blue, a),
                           mix_channel(p[15:8], line_green, a),
                           mix_channel(p[7:0], line_red, a)};
   endtask

   // walk the columns of one segment and blend into the shadow frame
   task automatic walk_segment(input longint x1, input longint y1, input longint x2,
                               input longint y2, output int cols);
      longint dx, dy, adx, ady, lo, hi, y, iy, f, o;
      dx = x2 - x1;
      dy = y2 - y1;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      cols = 0;
      if (adx <= ady || dx <= 0) return;
      lo = floor_div(x1, 16);
      hi = floor_div(x2, 16);
      if (lo < 0) lo = 0;
      if (hi > albe_pkg::FRAME_WIDTH) hi = albe_pkg::FRAME_WIDTH;
      for (longint c = lo; c < hi; c++) begin
         y = y1 * 4096 + floor_div((16 * c + 8 - x1) * dy * 4096, dx);
         iy = floor_div(y, 65536);
         f = y - iy * 65536;
         if (f > 32768) begin
            o = f - 32768;
            mix_pixel(c, iy, 65536 - o);
            mix_pixel(c, iy + 1, o);
         end else begin
            o = 32768 - f;
            mix_pixel(c, iy, 65536 - o);
            mix_pixel(c, iy - 1, o);
         end
         cols++;
      end
   endtask

   // expected beat for the command now on the request ports
   task automatic predict_command();
      logic [23:0] rgb;
      int cols;
      int idx;
      rgb = '0;
      cols = 0;
      idx = int'(req_pixel_col) + albe_pkg::FRAME_WIDTH * int'(req_pixel_row);
      case (req_operation)
         albe_pkg::OP_WRITE: shadow_frame[idx] = req_pixel_rgb;
         albe_pkg::OP_READ:  rgb = shadow_frame[idx];
         albe_pkg::OP_DRAW: begin
            walk_segment(req_start_x, req_start_y, req_end_x, req_end_y, cols);
            draws_sent++;
         end
         default: ;
      endcase
      pending_rgb.push_back(rgb);
      pending_cols.push_back(9'(cols));
   endtask

   // send one command beat, with a random gap in front of it at the chance given by idle_pct
   task automatic send_command(input logic [1:0] op, input int x1, input int y1,
                               input int x2, input int y2, input logic [7:0] col,
                               input logic [7:0] row, input logic [23:0] rgb);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_start_x <= 16'(x1);
      req_start_y <= 16'(y1);
      req_end_x <= 16'(x2);
      req_end_y <= 16'(y2);
      req_pixel_col <= col;
      req_pixel_row <= row;
      req_pixel_rgb <= rgb;
      do @(posedge clock); while (busy);
      predict_command();
      beats_sent++;
   endtask

   task automatic send_draw(input int x1, input int y1, input int x2, input int y2);
      send_command(albe_pkg::OP_DRAW, x1, y1, x2, y2, 8'($urandom), 8'($urandom),
                   24'($urandom));
   endtask

   // wait until every expected beat has come back
   task automatic drain();
      start <= 1'b0;
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write enable stays high across a run of writes, the caller drops it
   task automatic set_register(input logic [2:0] idx, input logic [7:0] value);
      start <= 1'b0;
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         albe_pkg::CSR_RED:   line_red = value;
         albe_pkg::CSR_GREEN: line_green = value;
         albe_pkg::CSR_BLUE:  line_blue = value;
         albe_pkg::CSR_ALPHA: line_opacity = value;
         albe_pkg::CSR_GAMMA: sqrt_blend = value[0];
         default: ;
      endcase
   endtask

   task automatic set_line(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [7:0] a, input logic gm);
      drain();
      set_register(albe_pkg::CSR_RED, r);
      set_register(albe_pkg::CSR_GREEN, g);
      set_register(albe_pkg::CSR_BLUE, b);
      set_register(albe_pkg::CSR_ALPHA, a);
      set_register(albe_pkg::CSR_GAMMA, {7'd0, gm});
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // load the corner square so that reads and random draws never see an unwritten pixel
   task automatic test_fill();
      idle_pct = 0;
      for (int i = 0; i < WIN * WIN; i++)
         send_command(albe_pkg::OP_WRITE, $urandom, $urandom, $urandom, $urandom,
                      8'(i % WIN), 8'(i / WIN), 24'($urandom));
      drain();
   endtask

   // corners, odd operation code and every draw corner case
   task automatic test_directed();
      idle_pct = 0;
      send_command(albe_pkg::OP_WRITE, 0, 0, 0, 0, 8'd0, 8'd0, 24'h000000);
      send_command(albe_pkg::OP_WRITE, -1, -1, -1, -1, 8'd255, 8'd255, 24'hffffff);
      send_command(albe_pkg::OP_READ, 0, 0, 0, 0, 8'd0, 8'd0, 24'd0);
      send_command(albe_pkg::OP_READ, 0, 0, 0, 0, 8'd255, 8'd255, 24'hffffff);
      send_command(OP_SPARE, -1, -1, -1, -1, 8'd255, 8'd255, 24'hffffff);
      // y-major, degenerate, leftward and sub-pixel segments
      send_draw(100, 100, 120, 200);
      send_draw(300, 300, 300, 300);
      send_draw(800, 100, 400, 120);
      send_draw(801, 100, 812, 101);
      // endpoint y at half a pixel, so the split falls exactly on half
      send_draw(32, 8, 200, 8);
      // off-frame columns on the left and right, off-frame rows above and below
      send_draw(-200, 40, 60, 50);
      send_draw(4000, -600, 4300, -590);
      send_draw(100, -30, 250, 10);
      send_draw(100, 4200, 400, 4230);
      // full range, every column of the frame
      send_draw(-32768, -8000, 32767, -7900);
      send_draw(-32768, 32767, 32767, -32767);
      send_draw(60, 200, 250, 120);
      send_command(albe_pkg::OP_READ, 0, 0, 0, 0, 8'd5, 8'd10, 24'd0);
      // opaque full white in linear mode, then transparent
      set_line(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      send_draw(16, 160, 250, 200);
      send_command(albe_pkg::OP_READ, 0, 0, 0, 0, 8'd5, 8'd10, 24'd0);
      set_line(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      send_draw(16, 170, 250, 150);
      send_command(albe_pkg::OP_READ, 0, 0, 0, 0, 8'd5, 8'd10, 24'd0);
      drain();
   endtask

   // random writes, reads and draws, the draws mostly short x-major segments over the corner square
   task automatic test_random(input int count, input int pct);
      int pick, span, x1, y1, dx, dy, x2, y2;
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_command(albe_pkg::OP_WRITE, $urandom, $urandom, $urandom, $urandom,
                         8'($urandom_range(0, WIN - 1)), 8'($urandom_range(0, WIN - 1)),
                         24'($urandom));
         end else if (pick < 50) begin
            send_command(albe_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom,
                         8'($urandom_range(0, WIN - 1)), 8'($urandom_range(0, WIN - 1)),
                         24'($urandom));
         end else if (pick < 96) begin
            span = ($urandom_range(0, 99) < 3) ? $urandom_range(9, 255) : $urandom_range(0, 8);
            x1 = $urandom_range(0, 300) - 80;
            dx = span * 16 + $urandom_range(0, 15);
            if (dx == 0) dx = 1;
            // last column stays inside the square
            if (x1 + dx > 16 * WIN - 1) dx = 16 * WIN - 1 - x1;
            x2 = x1 + dx;
            dy = $urandom_range(0, 2 * (dx - 1)) - (dx - 1);
            // both rows of every split stay inside the square
            y1 = $urandom_range(32, 16 * (WIN - 3));
            y2 = y1 + dy;
            if (y2 < 32) y2 = 32;
            if (y2 > 16 * (WIN - 3)) y2 = 16 * (WIN - 3);
            send_draw(x1, y1, x2, y2);
         end else begin
            // raw noise: any operation code, any x, rows far above the frame
            send_command(2'($urandom), $urandom, $urandom_range(0, 28000) - 32768,
                         $urandom, $urandom_range(0, 28000) - 32768,
                         8'($urandom_range(0, WIN - 1)), 8'($urandom_range(0, WIN - 1)),
                         24'($urandom));
         end
      end
      drain();
   endtask

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rgb.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: rgb %h cols %0d", rsp_read_rgb, rsp_columns_drawn);
         end else begin
            logic [23:0] exp_rgb;
            logic [8:0]  exp_cols;
            exp_rgb = pending_rgb.pop_front();
            exp_cols = pending_cols.pop_front();
            if (rsp_read_rgb !== exp_rgb || rsp_columns_drawn !== exp_cols) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat mismatch: rgb exp %h got %h, cols exp %0d got %0d",
                           exp_rgb, rsp_read_rgb, exp_cols, rsp_columns_drawn);
            end
         end
      end
   end

   // watchdog on cycles with nothing accepted and no result beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      mismatches = 0;
      beats_sent = 0;
      draws_sent = 0;
      watchdog = 0;
      idle_pct = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_operation <= albe_pkg::OP_WRITE;
      req_start_x <= '0;
      req_start_y <= '0;
      req_end_x <= '0;
      req_end_y <= '0;
      req_pixel_col <= '0;
      req_pixel_row <= '0;
      req_pixel_rgb <= '0;
      csr_write <= 1'b0;
      csr_index <= albe_pkg::CSR_RED;
      csr_data <= '0;
      line_red = 8'd0;
      line_green = 8'd255;
      line_blue = 8'd255;
      line_opacity = 8'd128;
      sqrt_blend = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill();
      test_directed();
      set_line(8'd0, 8'd255, 8'd255, 8'd128, 1'b1);
      test_random(220, 0);
      set_line(8'd255, 8'd0, 8'd128, 8'd255, 1'b0);
      test_random(220, 57);
      set_line(8'd17, 8'd200, 8'd3, 8'd0, 1'b1);
      test_random(160, 0);
      set_line(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      test_random(290, 23);

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d command beats, %0d of them draws, over several line settings",
               beats_sent, draws_sent);
      $display("corner pixels, clipped and rejected segments, both blend modes, idle gaps");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
